// File: rtl/vcf_pkg.sv
// Shared types and constants for the vending controller.
`timescale 1ns / 1ps

package vcf_pkg;

   // Field widths of the request and response words
   localparam int unsigned ACT_W  = 3;
   localparam int unsigned CNT_W  = 10;
   localparam int unsigned PIN_W  = 17;
   localparam int unsigned MODE_W = 3;
   localparam int unsigned STAT_W = 3;

   // Default saturation limit of the stock and credit counters
   localparam int unsigned COUNT_MAX_DEFAULT = 1023;

   // Maintenance PIN after reset
   localparam logic [PIN_W-1:0] PIN_RESET = PIN_W'(54321);

   // Event codes
   localparam logic [ACT_W-1:0] ACT_INSERT   = ACT_W'(0);
   localparam logic [ACT_W-1:0] ACT_SELECT   = ACT_W'(1);
   localparam logic [ACT_W-1:0] ACT_REJECT   = ACT_W'(2);
   localparam logic [ACT_W-1:0] ACT_RESTOCK  = ACT_W'(3);
   localparam logic [ACT_W-1:0] ACT_DISPENSE = ACT_W'(4);
   localparam logic [ACT_W-1:0] ACT_PIN      = ACT_W'(5);
   localparam logic [ACT_W-1:0] ACT_EXIT     = ACT_W'(6);

   // Machine modes
   localparam logic [MODE_W-1:0] MODE_EMPTY    = MODE_W'(0);
   localparam logic [MODE_W-1:0] MODE_NOCREDIT = MODE_W'(1);
   localparam logic [MODE_W-1:0] MODE_CREDIT   = MODE_W'(2);
   localparam logic [MODE_W-1:0] MODE_DISPENSE = MODE_W'(3);
   localparam logic [MODE_W-1:0] MODE_MAINT    = MODE_W'(4);

   // Status codes
   localparam logic [STAT_W-1:0] STAT_OK        = STAT_W'(0);
   localparam logic [STAT_W-1:0] STAT_REFUSED   = STAT_W'(1);
   localparam logic [STAT_W-1:0] STAT_BADPIN    = STAT_W'(2);
   localparam logic [STAT_W-1:0] STAT_NOSTOCK   = STAT_W'(3);
   localparam logic [STAT_W-1:0] STAT_NOCREDIT  = STAT_W'(4);

   typedef struct packed {
      logic [ACT_W-1:0] action;
      logic [CNT_W-1:0] credit_added;
      logic [CNT_W-1:0] bars_selected;
      logic [CNT_W-1:0] bars_added;
      logic [PIN_W-1:0] pin_entered;
   } req_type;

   typedef struct packed {
      logic              accepted;
      logic [STAT_W-1:0] status;
      logic [MODE_W-1:0] mode_now;
      logic [CNT_W-1:0]  bars_in_stock;
      logic [CNT_W-1:0]  credit_left;
   } rsp_type;

endpackage

// File: rtl/vcf_step.sv
// Event decode and next-state logic for one vending event.
`timescale 1ns / 1ps

module vcf_step #(
   parameter int unsigned COUNT_MAX = vcf_pkg::COUNT_MAX_DEFAULT,
   localparam int unsigned CW = $clog2(COUNT_MAX + 1)
) (
   input  vcf_pkg::req_type                 req,
   input  logic [vcf_pkg::PIN_W-1:0]        pin,
   input  logic [vcf_pkg::MODE_W-1:0]       mode_cur,
   input  logic [CW-1:0]                    bar_cur,
   input  logic [CW-1:0]                    credit_cur,
   output logic [vcf_pkg::MODE_W-1:0]       mode_nxt,
   output logic [CW-1:0]                    bar_nxt,
   output logic [CW-1:0]                    credit_nxt,
   output vcf_pkg::rsp_type                 rsp
);
   import vcf_pkg::*;

   localparam int unsigned SW = ((CW > CNT_W) ? CW : CNT_W) + 1;
   localparam logic [SW-1:0] LIMIT = SW'(COUNT_MAX);
   localparam logic [CW-1:0] TOP   = CW'(COUNT_MAX);

   logic [SW-1:0] bar_ext, credit_ext, sel_ext;
   logic [SW-1:0] bar_sum, credit_sum;
   logic [SW-1:0] bar_out_ext, credit_out_ext;
   logic [CW-1:0] bar_sat, credit_sat;
   logic [CW-1:0] sel_cut;
   logic          bar_zero, credit_zero;
   logic          acc_nxt;
   logic [STAT_W-1:0] stat_nxt;

   // Widen operands so sums and compares never wrap
   assign bar_ext    = SW'(bar_cur);
   assign credit_ext = SW'(credit_cur);
   assign sel_ext    = SW'(req.bars_selected);
   assign sel_cut    = sel_ext[CW-1:0];
   assign bar_zero   = (bar_cur == '0);
   assign credit_zero = (credit_cur == '0);

   // Saturating adds for restock and insert money
   assign bar_sum    = bar_ext + SW'(req.bars_added);
   assign credit_sum = credit_ext + SW'(req.credit_added);
   assign bar_sat    = (bar_sum > LIMIT) ? TOP : bar_sum[CW-1:0];
   assign credit_sat = (credit_sum > LIMIT) ? TOP : credit_sum[CW-1:0];

   // Decode the event against the current mode; first match wins
   always_comb begin
      mode_nxt   = mode_cur;
      bar_nxt    = bar_cur;
      credit_nxt = credit_cur;
      acc_nxt    = 1'b1;
      stat_nxt   = STAT_OK;
      priority if (mode_cur == MODE_EMPTY && req.action == ACT_RESTOCK) begin
         bar_nxt  = bar_sat;
         mode_nxt = MODE_NOCREDIT;
      end else if ((mode_cur == MODE_EMPTY || mode_cur == MODE_NOCREDIT)
                   && req.action == ACT_PIN) begin
         if (req.pin_entered == pin) begin
            mode_nxt = MODE_MAINT;
         end else begin
            stat_nxt = STAT_BADPIN;
         end
      end else if (mode_cur == MODE_EMPTY && req.action == ACT_REJECT) begin
         credit_nxt = '0;
      end else if ((mode_cur == MODE_NOCREDIT || mode_cur == MODE_CREDIT)
                   && req.action == ACT_INSERT) begin
         credit_nxt = credit_sat;
         mode_nxt   = MODE_CREDIT;
      end else if (mode_cur == MODE_CREDIT && req.action == ACT_SELECT) begin
         // Stock is checked before credit
         if (bar_ext < sel_ext) begin
            stat_nxt = STAT_NOSTOCK;
         end else if (credit_ext < sel_ext) begin
            stat_nxt = STAT_NOCREDIT;
         end else begin
            bar_nxt    = bar_cur - sel_cut;
            credit_nxt = credit_cur - sel_cut;
            mode_nxt   = MODE_DISPENSE;
         end
      end else if (mode_cur == MODE_CREDIT && req.action == ACT_REJECT) begin
         credit_nxt = '0;
         mode_nxt   = MODE_NOCREDIT;
      end else if (mode_cur == MODE_DISPENSE && req.action == ACT_DISPENSE) begin
         if (bar_zero) begin
            mode_nxt = MODE_EMPTY;
         end else if (credit_zero) begin
            mode_nxt = MODE_NOCREDIT;
         end else begin
            mode_nxt = MODE_CREDIT;
         end
      end else if (mode_cur == MODE_MAINT && req.action == ACT_EXIT) begin
         if (!bar_zero && credit_zero) begin
            mode_nxt = MODE_NOCREDIT;
         end else if (!bar_zero) begin
            mode_nxt = MODE_CREDIT;
         end else begin
            mode_nxt = MODE_EMPTY;
         end
      end else if (mode_cur == MODE_MAINT && req.action == ACT_RESTOCK) begin
         // Restock in maintenance is taken but leaves the counts alone
         mode_nxt = mode_cur;
      end else begin
         acc_nxt  = 1'b0;
         stat_nxt = STAT_REFUSED;
      end
   end

   // Report the post-event mode and counts
   assign bar_out_ext    = SW'(bar_nxt);
   assign credit_out_ext = SW'(credit_nxt);
   assign rsp = '{accepted:      acc_nxt,
                  status:        stat_nxt,
                  mode_now:      mode_nxt,
                  bars_in_stock: bar_out_ext[CNT_W-1:0],
                  credit_left:   credit_out_ext[CNT_W-1:0]};

endmodule

// File: rtl/vending_controller_fsm.sv
// Top level of the vending controller: request register, event logic, response register.
`timescale 1ns / 1ps

// Vending controller taking one event word per clock, while the response channel
// does not stall, and returning one response word per event. A word accepted on
// the request channel lands in an input register; the event logic then resolves
// it against the mode, stock and credit registers, updates them, and loads the
// response register, and without backpressure the block sustains one event every
// cycle. Updating the mode and counter registers in the same cycle as the response
// register is what sets that rate. Backpressure on the response channel stalls the
// input register and then the request channel. The maintenance PIN is written on
// the CSR channel, which is always ready outside reset, and should only be written
// while no event is in flight. Counters saturate at COUNT_MAX.
module vending_controller_fsm #(
   parameter int unsigned COUNT_MAX = vcf_pkg::COUNT_MAX_DEFAULT
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  vcf_pkg::req_type            req,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output vcf_pkg::rsp_type            rsp,
   input  logic                        csr_valid,
   output logic                        csr_ready,
   input  logic [vcf_pkg::PIN_W-1:0]   csr_data
);
   import vcf_pkg::*;

   localparam int unsigned CW = $clog2(COUNT_MAX + 1);

   req_type            req_ff;
   logic               req_valid_ff;
   rsp_type            rsp_ff, rsp_in;
   logic               rsp_valid_ff;
   logic [MODE_W-1:0]  mode_ff, mode_in;
   logic [CW-1:0]      bar_ff, bar_in;
   logic [CW-1:0]      credit_ff, credit_in;
   logic [PIN_W-1:0]   pin_ff;
   logic               advance;

   // Move the held event into the response register when it is free
   assign advance   = req_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !reset && (!req_valid_ff || advance);
   assign csr_ready = !reset;
   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

   vcf_step #(
      .COUNT_MAX (COUNT_MAX)
   ) u_step (
      .req        (req_ff),
      .pin        (pin_ff),
      .mode_cur   (mode_ff),
      .bar_cur    (bar_ff),
      .credit_cur (credit_ff),
      .mode_nxt   (mode_in),
      .bar_nxt    (bar_in),
      .credit_nxt (credit_in),
      .rsp        (rsp_in)
   );

   // Hold control and machine state
   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         mode_ff      <= MODE_EMPTY;
         bar_ff       <= '0;
         credit_ff    <= '0;
         pin_ff       <= PIN_RESET;
      end else begin
         if (req_ready) begin
            req_valid_ff <= req_valid;
         end
         if (advance) begin
            rsp_valid_ff <= 1'b1;
            mode_ff      <= mode_in;
            bar_ff       <= bar_in;
            credit_ff    <= credit_in;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (csr_valid) begin
            pin_ff <= csr_data;
         end
      end
   end

   // Capture payload words
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         req_ff <= req;
      end
      if (advance) begin
         rsp_ff <= rsp_in;
      end
   end

endmodule

// File: rtl/vcf_checker.sv
// Port-level checks for the vending controller, bound to the top level.
`timescale 1ns / 1ps

module vcf_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_ready,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input vcf_pkg::rsp_type  rsp
);
   import vcf_pkg::*;

   rsp_type last_ff;

   // Track the last delivered word; reset matches the machine's reset state
   always_ff @(posedge clock) begin
      if (reset) begin
         last_ff <= '0;
      end else if (rsp_valid && rsp_ready) begin
         last_ff <= rsp;
      end
   end

   // A stalled response word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
      else $error("response word changed while stalled");

   // A rising response valid only follows a request that was taken and passed through the input register
   a_rsp_origin: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_valid && req_ready, 2))
      else $error("response appeared without a request");

   // A refused event reports the refused status and leaves state untouched
   a_refused: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp.accepted |->
         rsp.status == STAT_REFUSED && rsp.mode_now == last_ff.mode_now
         && rsp.bars_in_stock == last_ff.bars_in_stock
         && rsp.credit_left == last_ff.credit_left)
      else $error("refused event changed state");

   // A short select changes nothing
   a_short: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp.status == STAT_NOSTOCK || rsp.status == STAT_NOCREDIT) |->
         rsp.mode_now == last_ff.mode_now
         && rsp.bars_in_stock == last_ff.bars_in_stock
         && rsp.credit_left == last_ff.credit_left)
      else $error("short select changed state");

endmodule

bind vending_controller_fsm vcf_checker u_vcf_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp       (rsp)
);
